/* design/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that expr never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

/* design/hsc_pkg.sv */
`default_nettype none

package hsc_pkg;

  localparam int unsigned ChW       = 8;
  localparam int unsigned MaxLabelW = 8;
  localparam int unsigned MaxNameW  = 10;
  localparam int unsigned LabelCntW = 9;
  localparam int unsigned NameCntW  = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;

  localparam logic [MaxLabelW-1:0] MaxLabelRst = 8'd63;
  localparam logic [MaxNameW-1:0]  MaxNameRst  = 10'd255;

  localparam logic [CfgIdxW-1:0] CfgMaxLabel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxName  = 2'd1;

  localparam logic [ChW-1:0] ChNul    = 8'h00;
  localparam logic [ChW-1:0] ChHyphen = 8'h2D;
  localparam logic [ChW-1:0] ChDot    = 8'h2E;

  // Class of one name byte, passed from the decoder to the state update.
  typedef struct packed {
    logic is_term;
    logic is_dot;
    logic is_hyphen;
    logic is_alnum;
  } char_class_t;

endpackage

`default_nettype wire

/* design/hsc_char_class.sv */
`default_nettype none

module hsc_char_class (
  input  wire logic [hsc_pkg::ChW-1:0] ch_i,
  output hsc_pkg::char_class_t         cls_o
);

  logic is_digit;
  logic is_upper;
  logic is_lower;

  assign is_digit = (ch_i >= 8'h30) && (ch_i <= 8'h39);
  assign is_upper = (ch_i >= 8'h41) && (ch_i <= 8'h5A);
  assign is_lower = (ch_i >= 8'h61) && (ch_i <= 8'h7A);

  always_comb begin
    cls_o.is_term   = (ch_i == hsc_pkg::ChNul);
    cls_o.is_dot    = (ch_i == hsc_pkg::ChDot);
    cls_o.is_hyphen = (ch_i == hsc_pkg::ChHyphen);
    cls_o.is_alnum  = is_digit | is_upper | is_lower;
  end

endmodule

`default_nettype wire

/* design/hsc_name_state.sv */
`default_nettype none

module hsc_name_state (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            adv_i,
  input  wire hsc_pkg::char_class_t            cls_i,
  input  wire logic [hsc_pkg::MaxLabelW-1:0]   max_label_i,
  input  wire logic [hsc_pkg::MaxNameW-1:0]    max_name_i,
  output logic                                 verdict_o
);

  logic [hsc_pkg::LabelCntW-1:0] label_cnt_q, label_cnt_d;
  logic [hsc_pkg::NameCntW-1:0]  name_cnt_q, name_cnt_d;
  logic                          hyph_q, hyph_d;
  logic                          err_q, err_d;

  logic                          label_bad;
  logic                          name_long;
  logic [hsc_pkg::LabelCntW-1:0] label_inc;
  logic [hsc_pkg::NameCntW-1:0]  name_inc;

  assign label_bad = (label_cnt_q == '0) || hyph_q ||
                     (label_cnt_q > {1'b0, max_label_i});
  assign name_long = name_cnt_q > {1'b0, max_name_i};
  assign verdict_o = !(err_q || label_bad || name_long);

  // Saturate both counters at all ones.
  assign label_inc = (&label_cnt_q) ? label_cnt_q : label_cnt_q + 1'b1;
  assign name_inc  = (&name_cnt_q) ? name_cnt_q : name_cnt_q + 1'b1;

  always_comb begin
    label_cnt_d = label_cnt_q;
    name_cnt_d  = name_cnt_q;
    hyph_d      = hyph_q;
    err_d       = err_q;
    if (adv_i) begin
      if (cls_i.is_term) begin
        label_cnt_d = '0;
        name_cnt_d  = '0;
        hyph_d      = 1'b0;
        err_d       = 1'b0;
      end else begin
        name_cnt_d = name_inc;
        if (cls_i.is_dot) begin
          err_d       = err_q | label_bad;
          label_cnt_d = '0;
          hyph_d      = 1'b0;
        end else if (cls_i.is_hyphen) begin
          // A label may not open with a hyphen.
          err_d       = err_q | (label_cnt_q == '0);
          hyph_d      = 1'b1;
          label_cnt_d = label_inc;
        end else begin
          err_d       = err_q | !cls_i.is_alnum;
          hyph_d      = 1'b0;
          label_cnt_d = label_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_cnt_q <= '0;
      name_cnt_q  <= '0;
      hyph_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      label_cnt_q <= label_cnt_d;
      name_cnt_q  <= name_cnt_d;
      hyph_q      <= hyph_d;
      err_q       <= err_d;
    end
  end

endmodule

`default_nettype wire

/* design/hostname_syntax_check_core.sv */
// Hostname syntax checker: one name byte per transfer, a zero byte ends the name.
// Throughput: one byte per cycle; only a stalled verdict holds back the next terminator.
// The byte passes an input register, the class decode and state update, then the
// verdict register. Reset clears the name state and loads limits 63 and 255.
`default_nettype none

module hostname_syntax_check_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [hsc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [hsc_pkg::ChW-1:0]        ch_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                valid_res_o
);

  logic [hsc_pkg::MaxLabelW-1:0] max_label_q;
  logic [hsc_pkg::MaxNameW-1:0]  max_name_q;

  logic                    in_vld_q;
  logic [hsc_pkg::ChW-1:0] ch_q;
  logic                    out_vld_q, out_vld_d;
  logic                    res_q;

  hsc_pkg::char_class_t cls;
  logic                 adv;
  logic                 verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_label_q <= hsc_pkg::MaxLabelRst;
      max_name_q  <= hsc_pkg::MaxNameRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hsc_pkg::CfgMaxLabel: max_label_q <= cfg_wdata_i[hsc_pkg::MaxLabelW-1:0];
        hsc_pkg::CfgMaxName:  max_name_q  <= cfg_wdata_i[hsc_pkg::MaxNameW-1:0];
        default: ;
      endcase
    end
  end

  hsc_char_class u_char_class (
    .ch_i  (ch_q),
    .cls_o (cls)
  );

  // Advance the held byte unless it is a terminator blocked by a stalled verdict.
  assign adv        = in_vld_q && (!cls.is_term || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  hsc_name_state u_name_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cls_i       (cls),
    .max_label_i (max_label_q),
    .max_name_i  (max_name_q),
    .verdict_o   (verdict)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (adv && cls.is_term) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q <= ch_i;
    end
    if (adv && cls.is_term) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o = out_vld_q;
  assign valid_res_o = res_q;

endmodule

`default_nettype wire

/* design/hsc_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module hsc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_we_i,
  input wire logic [hsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [hsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [hsc_pkg::ChW-1:0]      ch_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic                         valid_res_o
);

  logic in_xfer;
  logic cfg_seen;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign cfg_seen = cfg_we_i && (cfg_idx_i == hsc_pkg::CfgMaxLabel) && (cfg_wdata_i == '0);

  // A stalled verdict holds.
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(valid_res_o), "verdict changed while stalled")

  // Input is taken whenever the result side can move.
  `ASSERT_CLK(a_in_flow, (!out_valid_o || out_ready_i) |-> in_ready_o, "input stalled without cause")

  // A name whose last byte is a hyphen fails.
  `ASSERT_CLK(a_hyphen_end, (in_xfer && ch_i == hsc_pkg::ChNul && $past(in_xfer && ch_i == hsc_pkg::ChHyphen && !cfg_seen)) ##1 (!out_valid_o || out_ready_i) |=> out_valid_o && !valid_res_o, "name ending in hyphen accepted")

endmodule

bind hostname_syntax_check_core hsc_checker u_hsc_checker (.*);

`default_nettype wire
